// ===== hw/rtl/ray_triangle_intersect_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ray/triangle intersection block
// Shared property forms, clocked on clk and idle while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_TOP_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_TOP_ASSERT_SVH

// Same-cycle implication
`define RTI_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// Types, constants and binary32 helpers shared by the intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int unsigned FW = 32;
    localparam int unsigned MW = 50;
    localparam int unsigned EW = 11;

    localparam logic [31:0] NEAR_LIMIT = 32'h33D6BF95;
    localparam logic [31:0] FP_ONE     = 32'h3F800000;
    localparam logic [31:0] FP_QNAN    = 32'h7FC00000;
    localparam logic [30:0] FP_INF_MAG = 31'h7F800000;

    // Unit latencies in cycles
    localparam int unsigned ADD_LAT   = 2;
    localparam int unsigned MUL_LAT   = 2;
    localparam int unsigned DIV_QBITS = 28;
    localparam int unsigned DIV_STEP  = 2;
    localparam int unsigned DIV_STAGES = DIV_QBITS / DIV_STEP;
    localparam int unsigned RCP_LAT   = DIV_STAGES + 2;
    localparam int unsigned PIPE_LAT  =
        ADD_LAT + MUL_LAT + ADD_LAT + MUL_LAT + 2 * ADD_LAT + RCP_LAT + MUL_LAT + ADD_LAT;

    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        logic [31:0] corner_a_x;
        logic [31:0] corner_a_y;
        logic [31:0] corner_a_z;
        logic [31:0] corner_b_x;
        logic [31:0] corner_b_y;
        logic [31:0] corner_b_z;
        logic [31:0] corner_c_x;
        logic [31:0] corner_c_y;
        logic [31:0] corner_c_z;
    } tri_in_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
        logic [2:0]  miss_reason;
    } res_out_t;

    typedef enum logic [2:0] {
        REASON_HIT      = 3'd0,
        REASON_PARALLEL = 3'd1,
        REASON_U_OUT    = 3'd2,
        REASON_V_OUT    = 3'd3,
        REASON_BEHIND   = 3'd4
    } miss_reason_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } reg_idx_t;

    // Unrounded result: value = man / 2^48 * 2^(exp - 127), or a fixed pattern
    typedef struct packed {
        logic          special;
        logic [31:0]   special_bits;
        logic          sign;
        logic [EW-1:0] exp;
        logic [MW-1:0] man;
    } fpre_t;

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // Normalize, denormalize when tiny, round to nearest even, pack
    function automatic logic [31:0] f_round(input fpre_t x);
        logic [MW-1:0]        m;
        logic [5:0]           lz;
        logic                 found;
        logic signed [EW-1:0] e;
        logic [5:0]           sh;
        logic                 extra;
        logic [23:0]          mant;
        logic                 up;
        logic [32:0]          pk;
        logic [31:0]          res;
        lz    = 6'd0;
        found = 1'b0;
        res   = 32'd0;
        for (int i = MW - 1; i >= 0; i--) begin
            if (!found && x.man[i]) begin
                lz    = 6'(MW - 1 - i);
                found = 1'b1;
            end
        end
        m = x.man << lz;
        e = $signed(x.exp) + 11'sd1 - $signed({5'b0, lz});
        if (e < 11'sd1) begin
            if (e < -11'sd48) begin
                sh = 6'd50;
            end
            else begin
                sh = 6'(11'sd1 - e);
            end
            extra = |(m & ((50'b1 << sh) - 50'b1));
            m     = (m >> sh) | {49'b0, extra};
            e     = 11'sd1;
        end
        mant = m[49:26];
        up   = m[25] & ((|m[24:0]) | mant[0]);
        pk   = ({22'b0, 11'(e - 11'sd1)} << 23) + {9'b0, mant} + {32'b0, up};
        if (x.special) begin
            res = x.special_bits;
        end
        else if (x.man == '0) begin
            res = {x.sign, 31'd0};
        end
        else if (pk >= 33'h07F800000) begin
            res = {x.sign, FP_INF_MAG};
        end
        else begin
            res = {x.sign, pk[30:0]};
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/rti_delay.sv =====
// ----------------------------------------------------------------------------
// rti_delay
// Enabled shift line that keeps operands aligned with the arithmetic stages.
// ----------------------------------------------------------------------------
module rti_delay #(
    parameter int unsigned WIDTH = rti_pkg::FW,
    parameter int unsigned DEPTH = rti_pkg::ADD_LAT
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);
    import rti_pkg::*;

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Advance all taps together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ===== hw/rtl/rti_fmul.sv =====
// ----------------------------------------------------------------------------
// rti_fmul
// Two-stage binary32 multiplier: mantissa product, then round and pack.
// ----------------------------------------------------------------------------
module rti_fmul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);
    import rti_pkg::*;

    fpre_t       pre_next;
    fpre_t       pre_reg;
    logic [31:0] res_reg;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [47:0] prod;

    // Unpack, multiply mantissas, sort out special operands
    always_comb
    begin
        ma   = {a[30:23] != 8'h00, a[22:0]};
        mb   = {b[30:23] != 8'h00, b[22:0]};
        ea   = (a[30:23] == 8'h00) ? 8'd1 : a[30:23];
        eb   = (b[30:23] == 8'h00) ? 8'd1 : b[30:23];
        prod = 48'(ma) * 48'(mb);
        pre_next.special      = 1'b0;
        pre_next.special_bits = FP_QNAN;
        pre_next.sign         = a[31] ^ b[31];
        pre_next.exp          = 11'($signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd125);
        pre_next.man          = {2'b0, prod};
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) ||
            (is_zero(a) && is_inf(b)))
        begin
            pre_next.special = 1'b1;
        end
        else if (is_inf(a) || is_inf(b))
        begin
            pre_next.special      = 1'b1;
            pre_next.special_bits = {a[31] ^ b[31], FP_INF_MAG};
        end
    end

    // Hold both stages while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg <= pre_next;
            res_reg <= f_round(pre_reg);
        end
    end

    assign y = res_reg;

endmodule

// ===== hw/rtl/rti_fadd.sv =====
// ----------------------------------------------------------------------------
// rti_fadd
// Two-stage binary32 adder/subtractor: align and add, then round and pack.
// ----------------------------------------------------------------------------
module rti_fadd (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        sub,
    output logic [31:0] y
);
    import rti_pkg::*;

    fpre_t       pre_next;
    fpre_t       pre_reg;
    logic [31:0] res_reg;
    logic [31:0] bb;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  e_big;
    logic [7:0]  e_sml;
    logic [7:0]  diff;
    logic [49:0] m_big;
    logic [49:0] m_sml;
    logic [49:0] shifted;
    logic        stk;
    logic [49:0] aligned;
    logic [49:0] total;

    // Order by magnitude, align the smaller operand, add or subtract
    always_comb
    begin
        bb    = {b[31] ^ sub, b[30:0]};
        big   = (a[30:0] < bb[30:0]) ? bb : a;
        sml   = (a[30:0] < bb[30:0]) ? a : bb;
        e_big = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
        e_sml = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
        diff  = e_big - e_sml;
        m_big = {1'b0, big[30:23] != 8'h00, big[22:0], 25'b0};
        m_sml = {1'b0, sml[30:23] != 8'h00, sml[22:0], 25'b0};
        if (diff >= 8'd50)
        begin
            shifted = '0;
            stk     = |m_sml;
        end
        else
        begin
            shifted = m_sml >> diff;
            stk     = |(m_sml & ((50'b1 << diff) - 50'b1));
        end
        aligned = shifted | {49'b0, stk};
        total   = (big[31] == sml[31]) ? m_big + aligned : m_big - aligned;

        pre_next.special      = 1'b0;
        pre_next.special_bits = FP_QNAN;
        pre_next.sign         = (total == '0) ? 1'b0 : big[31];
        pre_next.exp          = {3'b0, e_big};
        pre_next.man          = total;
        if (is_nan(a) || is_nan(bb) || (is_inf(a) && is_inf(bb) && (a[31] != bb[31])))
        begin
            pre_next.special = 1'b1;
        end
        else if (is_inf(a))
        begin
            pre_next.special      = 1'b1;
            pre_next.special_bits = a;
        end
        else if (is_inf(bb))
        begin
            pre_next.special      = 1'b1;
            pre_next.special_bits = bb;
        end
        else if (is_zero(a) && is_zero(bb))
        begin
            pre_next.special      = 1'b1;
            pre_next.special_bits = {a[31] & bb[31], 31'd0};
        end
    end

    // Hold both stages while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg <= pre_next;
            res_reg <= f_round(pre_reg);
        end
    end

    assign y = res_reg;

endmodule

// ===== hw/rtl/rti_frecip.sv =====
// ----------------------------------------------------------------------------
// rti_frecip
// Pipelined binary32 reciprocal: unpack, restoring division a few quotient
// bits per stage, then round and pack.
// ----------------------------------------------------------------------------
module rti_frecip (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    output logic [31:0] y
);
    import rti_pkg::*;

    typedef struct packed {
        logic                 special;
        logic [31:0]          special_bits;
        logic                 sign;
        logic [EW-1:0]        exp;
        logic [23:0]          dvsr;
        logic [24:0]          rem;
        logic [DIV_QBITS-1:0] quo;
    } div_t;

    div_t        st_next [DIV_STAGES+1];
    div_t        st_reg  [DIV_STAGES+1];
    fpre_t       pre;
    logic [31:0] res_reg;
    logic [23:0] md;
    logic [4:0]  lz;
    logic        found;
    logic [7:0]  e_eff;

    // Unpack and normalize the divisor mantissa
    always_comb
    begin
        md    = {a[30:23] != 8'h00, a[22:0]};
        e_eff = (a[30:23] == 8'h00) ? 8'd1 : a[30:23];
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--)
        begin
            if (!found && md[i])
            begin
                lz    = 5'(23 - i);
                found = 1'b1;
            end
        end
        st_next[0].special      = 1'b0;
        st_next[0].special_bits = FP_QNAN;
        st_next[0].sign         = a[31];
        st_next[0].exp          = 11'(11'sd274 - ($signed({3'b0, e_eff}) - $signed({6'b0, lz})));
        st_next[0].dvsr         = md << lz;
        st_next[0].rem          = 25'h0800000;
        st_next[0].quo          = '0;
        if (is_nan(a))
        begin
            st_next[0].special = 1'b1;
        end
        else if (is_inf(a))
        begin
            st_next[0].special      = 1'b1;
            st_next[0].special_bits = {a[31], 31'd0};
        end
        else if (is_zero(a))
        begin
            st_next[0].special      = 1'b1;
            st_next[0].special_bits = {a[31], FP_INF_MAG};
        end
    end

    // Restoring division steps, DIV_STEP quotient bits per stage
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        always_comb
        begin
            div_t cur;
            logic bit_set;
            cur = st_reg[s];
            for (int j = 0; j < DIV_STEP; j++)
            begin
                bit_set = cur.rem >= {1'b0, cur.dvsr};
                if (bit_set)
                begin
                    cur.rem = cur.rem - {1'b0, cur.dvsr};
                end
                cur.quo = {cur.quo[DIV_QBITS-2:0], bit_set};
                cur.rem = cur.rem << 1;
            end
            st_next[s+1] = cur;
        end
    end

    // Quotient plus sticky into the common rounding form
    always_comb
    begin
        pre.special      = st_reg[DIV_STAGES].special;
        pre.special_bits = st_reg[DIV_STAGES].special_bits;
        pre.sign         = st_reg[DIV_STAGES].sign;
        pre.exp          = st_reg[DIV_STAGES].exp;
        pre.man          = MW'({st_reg[DIV_STAGES].quo, st_reg[DIV_STAGES].rem != 25'd0});
    end

    // Advance every stage together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                st_reg[i] <= st_next[i];
            end
            res_reg <= f_round(pre);
        end
    end

    assign y = res_reg;

endmodule

// ===== hw/rtl/ray_triangle_intersect_top.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Throughput: one triangle per cycle unless a held result stalls the pipeline;
// the pipeline is built from registered adders and multipliers and a reciprocal
// (two quotient bits per stage, 14 stages).
// A stalled result freezes every stage; nothing is dropped or repeated.
// Reset clears all valid bits and sets the ray registers to +0.0.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_top_assert.svh"

module ray_triangle_intersect_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tri_valid,
    output logic              tri_stall,
    input  rti_pkg::tri_in_t  tri_data,
    output logic              res_valid,
    input  logic              res_stall,
    output rti_pkg::res_out_t res_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rti_pkg::*;

    logic [31:0] origin_reg [3];
    logic [31:0] dir_reg    [3];
    logic        vld_reg    [PIPE_LAT];
    logic        res_valid_reg;
    res_out_t    res_reg;
    res_out_t    res_next;
    logic        en;

    vec3_t       org;
    vec3_t       dir;
    vec3_t       va;
    vec3_t       vb;
    vec3_t       vc;
    vec3_t       ab;
    vec3_t       ac;
    vec3_t       w;
    vec3_t       ab_d;
    vec3_t       ac_d;
    vec3_t       w_d;
    vec3_t       p_m0;
    vec3_t       p_m1;
    vec3_t       q_m0;
    vec3_t       q_m1;
    vec3_t       p;
    vec3_t       q;
    vec3_t       dot_l [4];
    vec3_t       dot_r [4];
    vec3_t       dot_m [4];
    logic [31:0] dot_xy [4];
    logic [31:0] dot_zd [4];
    logic [31:0] dot_s  [4];
    logic [31:0] inv;
    vec3_t       num;
    vec3_t       num_d;
    vec3_t       bar;
    vec3_t       bar_d;
    logic [31:0] bsum;
    logic [31:0] det_d;
    logic        det_small;
    logic        u_out;
    logic        v_out;
    logic        dist_ok;

    // Whole pipeline advances unless a finished result is held
    assign en        = !(res_valid_reg && res_stall);
    assign tri_stall = !en;
    assign pready    = 1'b1;

    // Ray registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i] <= 32'd0;
                dir_reg[i]    <= 32'd0;
            end
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_ORIGIN_X: origin_reg[0] <= pwdata;
                REG_ORIGIN_Y: origin_reg[1] <= pwdata;
                REG_ORIGIN_Z: origin_reg[2] <= pwdata;
                REG_DIR_X:    dir_reg[0]    <= pwdata;
                REG_DIR_Y:    dir_reg[1]    <= pwdata;
                REG_DIR_Z:    dir_reg[2]    <= pwdata;
                default:      ;
            endcase
        end
    end

    // Register read mux
    always_comb
    begin
        unique case (paddr[4:2])
            REG_ORIGIN_X: prdata = origin_reg[0];
            REG_ORIGIN_Y: prdata = origin_reg[1];
            REG_ORIGIN_Z: prdata = origin_reg[2];
            REG_DIR_X:    prdata = dir_reg[0];
            REG_DIR_Y:    prdata = dir_reg[1];
            REG_DIR_Z:    prdata = dir_reg[2];
            default:      prdata = 32'd0;
        endcase
    end

    assign org = {origin_reg[2], origin_reg[1], origin_reg[0]};
    assign dir = {dir_reg[2], dir_reg[1], dir_reg[0]};
    assign va  = {tri_data.corner_a_z, tri_data.corner_a_y, tri_data.corner_a_x};
    assign vb  = {tri_data.corner_b_z, tri_data.corner_b_y, tri_data.corner_b_x};
    assign vc  = {tri_data.corner_c_z, tri_data.corner_c_y, tri_data.corner_c_x};

    // Edges and origin offset
    for (genvar k = 0; k < 3; k++)
    begin : g_edge
        rti_fadd u_ab (.clk(clk), .en(en), .a(vb[k]),  .b(va[k]), .sub(1'b1), .y(ab[k]));
        rti_fadd u_ac (.clk(clk), .en(en), .a(vc[k]),  .b(va[k]), .sub(1'b1), .y(ac[k]));
        rti_fadd u_w  (.clk(clk), .en(en), .a(org[k]), .b(va[k]), .sub(1'b1), .y(w[k]));
    end

    rti_delay #(.WIDTH(96), .DEPTH(MUL_LAT + ADD_LAT)) u_ab_dly
        (.clk(clk), .en(en), .din(ab), .dout(ab_d));
    rti_delay #(.WIDTH(96), .DEPTH(MUL_LAT + ADD_LAT)) u_ac_dly
        (.clk(clk), .en(en), .din(ac), .dout(ac_d));
    rti_delay #(.WIDTH(96), .DEPTH(MUL_LAT + ADD_LAT)) u_w_dly
        (.clk(clk), .en(en), .din(w), .dout(w_d));

    // Cross products p = dir x ac and q = w x ab
    for (genvar k = 0; k < 3; k++)
    begin : g_cross
        localparam int unsigned K1 = (k + 1) % 3;
        localparam int unsigned K2 = (k + 2) % 3;
        rti_fmul u_pm0 (.clk(clk), .en(en), .a(dir[K1]), .b(ac[K2]), .y(p_m0[k]));
        rti_fmul u_pm1 (.clk(clk), .en(en), .a(ac[K1]), .b(dir[K2]), .y(p_m1[k]));
        rti_fmul u_qm0 (.clk(clk), .en(en), .a(w[K1]), .b(ab[K2]), .y(q_m0[k]));
        rti_fmul u_qm1 (.clk(clk), .en(en), .a(ab[K1]), .b(w[K2]), .y(q_m1[k]));
        rti_fadd u_p (.clk(clk), .en(en), .a(p_m0[k]), .b(p_m1[k]), .sub(1'b1), .y(p[k]));
        rti_fadd u_q (.clk(clk), .en(en), .a(q_m0[k]), .b(q_m1[k]), .sub(1'b1), .y(q[k]));
    end

    // Dot products: det, w.p, dir.q, ac.q
    assign dot_l[0] = ab_d;
    assign dot_r[0] = p;
    assign dot_l[1] = w_d;
    assign dot_r[1] = p;
    assign dot_l[2] = dir;
    assign dot_r[2] = q;
    assign dot_l[3] = ac_d;
    assign dot_r[3] = q;

    for (genvar j = 0; j < 4; j++)
    begin : g_dot
        for (genvar k = 0; k < 3; k++)
        begin : g_term
            rti_fmul u_m (.clk(clk), .en(en), .a(dot_l[j][k]), .b(dot_r[j][k]),
                          .y(dot_m[j][k]));
        end
        rti_fadd u_xy (.clk(clk), .en(en), .a(dot_m[j][0]), .b(dot_m[j][1]), .sub(1'b0),
                       .y(dot_xy[j]));
        rti_delay #(.WIDTH(FW), .DEPTH(ADD_LAT)) u_z_dly
            (.clk(clk), .en(en), .din(dot_m[j][2]), .dout(dot_zd[j]));
        rti_fadd u_s (.clk(clk), .en(en), .a(dot_xy[j]), .b(dot_zd[j]), .sub(1'b0),
                      .y(dot_s[j]));
    end

    // Reciprocal of det; hold the other dots alongside
    rti_frecip u_rcp (.clk(clk), .en(en), .a(dot_s[0]), .y(inv));

    assign num = {dot_s[3], dot_s[2], dot_s[1]};

    rti_delay #(.WIDTH(96), .DEPTH(RCP_LAT)) u_num_dly
        (.clk(clk), .en(en), .din(num), .dout(num_d));

    // Scale to bu, bv and dist
    for (genvar k = 0; k < 3; k++)
    begin : g_scale
        rti_fmul u_bar (.clk(clk), .en(en), .a(inv), .b(num_d[k]), .y(bar[k]));
    end

    rti_fadd u_sum (.clk(clk), .en(en), .a(bar[0]), .b(bar[1]), .sub(1'b0), .y(bsum));

    rti_delay #(.WIDTH(96), .DEPTH(ADD_LAT)) u_bar_dly
        (.clk(clk), .en(en), .din(bar), .dout(bar_d));
    rti_delay #(.WIDTH(FW), .DEPTH(RCP_LAT + MUL_LAT + ADD_LAT)) u_det_dly
        (.clk(clk), .en(en), .din(dot_s[0]), .dout(det_d));

    // Range tests; any compare against a NaN is false
    always_comb
    begin
        det_small = det_d[30:0] < NEAR_LIMIT[30:0];
        u_out     = !is_nan(bar_d[0]) &&
                    ((bar_d[0][31] && bar_d[0][30:0] != 31'd0) ||
                     (!bar_d[0][31] && bar_d[0][30:0] > FP_ONE[30:0]));
        v_out     = (!is_nan(bar_d[1]) && bar_d[1][31] && bar_d[1][30:0] != 31'd0) ||
                    (!is_nan(bsum) && !bsum[31] && bsum[30:0] > FP_ONE[30:0]);
        dist_ok   = !is_nan(bar_d[2]) && !bar_d[2][31] &&
                    bar_d[2][30:0] > NEAR_LIMIT[30:0];

        res_next.hit         = 1'b0;
        res_next.distance    = 32'd0;
        res_next.miss_reason = REASON_BEHIND;
        if (det_small)
        begin
            res_next.miss_reason = REASON_PARALLEL;
        end
        else if (u_out)
        begin
            res_next.miss_reason = REASON_U_OUT;
        end
        else if (v_out)
        begin
            res_next.miss_reason = REASON_V_OUT;
        end
        else if (dist_ok)
        begin
            res_next.hit         = 1'b1;
            res_next.distance    = bar_d[2];
            res_next.miss_reason = REASON_HIT;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= tri_valid;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            res_valid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    `RTI_ASSERT_IMPLY(a_hit_code, res_valid && res_data.hit,
        res_data.miss_reason == REASON_HIT, "hit beat carries a miss reason")
    `RTI_ASSERT_IMPLY(a_miss_dist, res_valid && !res_data.hit,
        res_data.distance == 32'd0, "miss beat carries a nonzero distance")
    `RTI_ASSERT_IMPLY(a_hit_ahead, res_valid && res_data.hit,
        !res_data.distance[31] && res_data.miss_reason != REASON_BEHIND,
        "hit beat with negative distance")
    `RTI_ASSERT_IMPLY(a_reason_range, res_valid,
        res_data.miss_reason <= REASON_BEHIND, "miss reason out of range")
    `RTI_ASSERT_NEXT(a_stall_hold, res_valid && res_stall && tri_stall,
        res_valid, "held result beat dropped")

endmodule

// ===== verif/ray_hit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_hit_checker
// Watches the triangle, result and register channels of the intersection
// block. Keeps its own copy of the ray registers, predicts every result
// with bit-exact binary32 arithmetic and compares each result beat in order.
// ----------------------------------------------------------------------------
module ray_hit_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tri_valid,
    input  logic              tri_stall,
    input  rti_pkg::tri_in_t  tri_data,
    input  logic              res_valid,
    input  logic              res_stall,
    input  rti_pkg::res_out_t res_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output int                fail_count,
    output int                pending
);
    import rti_pkg::*;

    typedef logic [31:0] f32_t;

    logic [31:0] ray_reg [6];
    res_out_t    hit_queue [$];

    // Split a finite nonzero value into integer significand and exponent
    function automatic void f_unpack(input f32_t x, output logic [127:0] m, output int e);
        if (x[30:23] == 8'd0)
        begin
            m = 128'(x[22:0]);
            e = -149;
        end
        else
        begin
            m = 128'({1'b1, x[22:0]});
            e = int'(x[30:23]) - 150;
        end
    endfunction

    // Round sig * 2^e2 to nearest even, subnormals kept
    function automatic f32_t f_pack(input logic s, input int e2, input logic [127:0] sig);
        int           p;
        int           sh;
        logic [127:0] mant;
        logic         g;
        logic         st;
        longint       b;
        p = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (sig[i]) p = i;
        end
        sh = p - 23;
        if (-149 - e2 > sh) sh = -149 - e2;
        g  = 1'b0;
        st = 1'b0;
        if (sh <= 0)
        begin
            mant = sig << (-sh);
        end
        else if (sh > 128)
        begin
            mant = '0;
            st   = 1'b1;
        end
        else
        begin
            mant = sig >> sh;
            g    = sig[sh-1];
            st   = |(sig & ((128'd1 << (sh - 1)) - 128'd1));
        end
        if (g && (st || mant[0])) mant = mant + 128'd1;
        b = (longint'(e2 + sh + 149) <<< 23) + longint'(mant[63:0]);
        if (b >= 64'h7F800000) return {s, FP_INF_MAG};
        return {s, b[30:0]};
    endfunction

    function automatic f32_t f_add(input f32_t a, input f32_t b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] fa;
        logic [127:0] fb;
        int           ea;
        int           eb;
        f32_t         t;
        if (is_nan(a) || is_nan(b)) return FP_QNAN;
        if (is_inf(a))
        begin
            if (is_inf(b) && a[31] != b[31]) return FP_QNAN;
            return a;
        end
        if (is_inf(b)) return b;
        if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
        if (is_zero(a)) return b;
        if (is_zero(b)) return a;
        f_unpack(a, ma, ea);
        f_unpack(b, mb, eb);
        // keep the larger exponent in a
        if (eb > ea)
        begin
            t = a; a = b; b = t;
            f_unpack(a, ma, ea);
            f_unpack(b, mb, eb);
        end
        fa = ma << 64;
        // a far smaller addend only acts as a sticky bit
        fb = (ea - eb <= 64) ? (mb << (64 - (ea - eb))) : 128'd1;
        if (a[31] == b[31]) return f_pack(a[31], ea - 64, fa + fb);
        if (fa == fb) return 32'd0;
        if (fa > fb) return f_pack(a[31], ea - 64, fa - fb);
        return f_pack(b[31], ea - 64, fb - fa);
    endfunction

    function automatic f32_t f_sub(input f32_t a, input f32_t b);
        return f_add(a, {~b[31], b[30:0]});
    endfunction

    function automatic f32_t f_mul(input f32_t a, input f32_t b);
        logic [127:0] ma;
        logic [127:0] mb;
        int           ea;
        int           eb;
        logic         s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return FP_QNAN;
        if (is_inf(a) || is_inf(b))
        begin
            if (is_zero(a) || is_zero(b)) return FP_QNAN;
            return {s, FP_INF_MAG};
        end
        if (is_zero(a) || is_zero(b)) return {s, 31'd0};
        f_unpack(a, ma, ea);
        f_unpack(b, mb, eb);
        return f_pack(s, ea + eb, ma * mb);
    endfunction

    // 1/x with a single rounding
    function automatic f32_t f_recip(input f32_t x);
        logic [127:0] m;
        logic [127:0] q;
        logic [127:0] r;
        int           e;
        if (is_nan(x)) return FP_QNAN;
        if (is_inf(x)) return {x[31], 31'd0};
        if (is_zero(x)) return {x[31], FP_INF_MAG};
        f_unpack(x, m, e);
        q = (128'd1 << 100) / m;
        r = (128'd1 << 100) % m;
        return f_pack(x[31], -101 - e, (q << 1) | 128'(r != 0));
    endfunction

    // a < b; false when either is NaN
    function automatic logic f_less(input f32_t a, input f32_t b);
        logic [31:0] ka;
        logic [31:0] kb;
        if (is_nan(a) || is_nan(b)) return 1'b0;
        if (is_zero(a) && is_zero(b)) return 1'b0;
        ka = a[31] ? ~a : (a | 32'h80000000);
        kb = b[31] ? ~b : (b | 32'h80000000);
        return ka < kb;
    endfunction

    function automatic f32_t f_dot(input vec3_t a, input vec3_t b);
        return f_add(f_add(f_mul(a[0], b[0]), f_mul(a[1], b[1])), f_mul(a[2], b[2]));
    endfunction

    function automatic vec3_t f_cross(input vec3_t a, input vec3_t b);
        vec3_t c;
        c[0] = f_sub(f_mul(a[1], b[2]), f_mul(b[1], a[2]));
        c[1] = f_sub(f_mul(a[2], b[0]), f_mul(b[2], a[0]));
        c[2] = f_sub(f_mul(a[0], b[1]), f_mul(b[0], a[1]));
        return c;
    endfunction

    // Moller-Trumbore against the current ray
    function automatic res_out_t intersect_ray(input tri_in_t t);
        vec3_t    va;
        vec3_t    vb;
        vec3_t    vc;
        vec3_t    orig;
        vec3_t    dir;
        vec3_t    ab;
        vec3_t    ac;
        vec3_t    p;
        vec3_t    w;
        vec3_t    q;
        f32_t     det;
        f32_t     inv;
        f32_t     bu;
        f32_t     bv;
        f32_t     hit_dist;
        res_out_t r;
        va   = {t.corner_a_z, t.corner_a_y, t.corner_a_x};
        vb   = {t.corner_b_z, t.corner_b_y, t.corner_b_x};
        vc   = {t.corner_c_z, t.corner_c_y, t.corner_c_x};
        orig = {ray_reg[REG_ORIGIN_Z], ray_reg[REG_ORIGIN_Y], ray_reg[REG_ORIGIN_X]};
        dir  = {ray_reg[REG_DIR_Z], ray_reg[REG_DIR_Y], ray_reg[REG_DIR_X]};
        r    = '0;
        for (int i = 0; i < 3; i++)
        begin
            ab[i] = f_sub(vb[i], va[i]);
            ac[i] = f_sub(vc[i], va[i]);
            w[i]  = f_sub(orig[i], va[i]);
        end
        p   = f_cross(dir, ac);
        det = f_dot(ab, p);
        if (f_less({1'b1, NEAR_LIMIT[30:0]}, det) && f_less(det, NEAR_LIMIT))
        begin
            r.miss_reason = REASON_PARALLEL;
            return r;
        end
        inv = f_recip(det);
        bu  = f_mul(inv, f_dot(w, p));
        if (f_less(bu, 32'd0) || f_less(FP_ONE, bu))
        begin
            r.miss_reason = REASON_U_OUT;
            return r;
        end
        q  = f_cross(w, ab);
        bv = f_mul(inv, f_dot(dir, q));
        if (f_less(bv, 32'd0) || f_less(FP_ONE, f_add(bu, bv)))
        begin
            r.miss_reason = REASON_V_OUT;
            return r;
        end
        hit_dist = f_mul(inv, f_dot(ac, q));
        if (f_less(NEAR_LIMIT, hit_dist))
        begin
            r.hit      = 1'b1;
            r.distance = hit_dist;
            r.miss_reason = REASON_HIT;
        end
        else
        begin
            r.miss_reason = REASON_BEHIND;
        end
        return r;
    endfunction

    // Track registers, queue predictions, compare result beats
    always @(posedge clk or negedge rst_n)
    begin
        res_out_t exp_res;
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++) ray_reg[i] = 32'd0;
            hit_queue.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[4:2] < 3'd6)
                ray_reg[paddr[4:2]] = pwdata;
            if (tri_valid && !tri_stall)
                hit_queue.push_back(intersect_ray(tri_data));
            if (res_valid && !res_stall)
            begin
                if (hit_queue.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: %h", $time, res_data);
                    fail_count++;
                end
                else
                begin
                    exp_res = hit_queue.pop_front();
                    if (res_data.hit !== exp_res.hit)
                    begin
                        $display("%0t: hit expected %b actual %b",
                                 $time, exp_res.hit, res_data.hit);
                        fail_count++;
                    end
                    if (res_data.distance !== exp_res.distance)
                    begin
                        $display("%0t: distance expected %h actual %h",
                                 $time, exp_res.distance, res_data.distance);
                        fail_count++;
                    end
                    if (res_data.miss_reason !== exp_res.miss_reason)
                    begin
                        $display("%0t: miss_reason expected %0d actual %0d",
                                 $time, exp_res.miss_reason, res_data.miss_reason);
                        fail_count++;
                    end
                end
            end
            pending = hit_queue.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives triangle beats and ray register writes into the intersection block
// over several ray settings and idle patterns; the checker predicts and
// compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import rti_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 240;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        tri_valid = 1'b0;
    logic        tri_stall;
    tri_in_t     tri_data = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_out_t    res_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    ray_triangle_intersect_top uut (
        .clk(clk), .rst_n(rst_n),
        .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_data(tri_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ray_hit_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_data(tri_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending)
    );

    always #1 clk = ~clk;

    // Stall results at random
    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Let the pipeline empty before touching the ray
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                           input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz);
        drain();
        reg_write(REG_ORIGIN_X, ox);
        reg_write(REG_ORIGIN_Y, oy);
        reg_write(REG_ORIGIN_Z, oz);
        reg_write(REG_DIR_X, dx);
        reg_write(REG_DIR_Y, dy);
        reg_write(REG_DIR_Z, dz);
    endtask

    // Offer one triangle beat and hold it until accepted
    task automatic send_tri(input tri_in_t t);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tri_valid = 1'b0;
            @(negedge clk);
        end
        tri_valid = 1'b1;
        tri_data  = t;
        do @(posedge clk); while (tri_stall);
    endtask

    function automatic tri_in_t mk_tri(
        input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
        input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
        input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz);
        return {ax, ay, az, bx, by, bz, cx, cy, cz};
    endfunction

    function automatic logic [31:0] coord(input int lo_exp, input int hi_exp, input logic neg_ok);
        return {neg_ok & 1'($urandom_range(1)), 8'($urandom_range(hi_exp, lo_exp)),
                23'($urandom)};
    endfunction

    function automatic logic [31:0] special_val();
        logic [31:0] pick [12] = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                                   32'h7FC00000, 32'hFFFFFFFF, 32'h00000001, 32'h807FFFFF,
                                   32'h7F7FFFFF, 32'h3F800000, 32'h33D6BF95, 32'hB3D6BF95};
        return pick[$urandom_range(11)];
    endfunction

    function automatic tri_in_t rand_tri();
        tri_in_t     t;
        logic [31:0] z;
        int          kind;
        kind = $urandom_range(99);
        z    = coord(126, 130, 1'b0);
        t    = mk_tri(coord(122, 128, 1'b1), coord(122, 128, 1'b1), z,
                      coord(122, 128, 1'b1), coord(122, 128, 1'b1), z,
                      coord(122, 128, 1'b1), coord(122, 128, 1'b1), z);
        if (kind < 35)
        begin
            // tilted triangle ahead of the origin
            t.corner_b_z = coord(126, 130, 1'b0);
            t.corner_c_z = coord(126, 130, 1'b0);
        end
        else if (kind < 70)
        begin
            // flat triangle, kept as drawn
        end
        else if (kind < 78)
        begin
            // plane holds the ray direction
            t.corner_b_x = t.corner_a_x;
            t.corner_c_x = t.corner_a_x;
        end
        else if (kind < 90)
        begin
            t.corner_a_x = special_val();
            t.corner_b_y = special_val();
            if ($urandom_range(1)) t.corner_c_z = special_val();
            if ($urandom_range(1)) t.corner_a_z = special_val();
        end
        else
        begin
            t = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        end
        return t;
    endfunction

    task automatic run_phase(input int phase);
        int spct [4] = '{0, 73, 0, 29};
        int rpct [4] = '{0, 0, 73, 29};
        send_idle_pct = spct[phase % 4];
        stall_pct     = rpct[phase % 4];
        for (int i = 0; i < RAND_ITEMS; i++) send_tri(rand_tri());
        @(negedge clk);
        tri_valid = 1'b0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed triangles against a ray along +z from the origin
        set_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h3F800000);
        // clean hit, parallel, u outside, v outside twice
        send_tri(mk_tri(32'hBF800000, 32'hBF800000, 32'h40A00000, 32'h3F800000, 32'hBF800000,
                        32'h40A00000, 32'h0, 32'h3F800000, 32'h40A00000));
        send_tri(mk_tri(32'h3F800000, 32'hBF800000, 32'h3F800000, 32'h3F800000, 32'h3F800000,
                        32'h3F800000, 32'h3F800000, 32'h0, 32'h40400000));
        send_tri(mk_tri(32'h3F800000, 32'h0, 32'h40A00000, 32'h40000000, 32'h0,
                        32'h40A00000, 32'h3F800000, 32'h3F800000, 32'h40A00000));
        send_tri(mk_tri(32'hBF800000, 32'h3F000000, 32'h40A00000, 32'h3F800000, 32'h3F000000,
                        32'h40A00000, 32'h0, 32'h40000000, 32'h40A00000));
        send_tri(mk_tri(32'hBF800000, 32'h3F000000, 32'h40A00000, 32'h3F800000, 32'hBF800000,
                        32'h40A00000, 32'hBF800000, 32'hBF800000, 32'h40A00000));
        // behind the origin, then too near
        send_tri(mk_tri(32'hBF800000, 32'hBF800000, 32'hC0A00000, 32'h3F800000, 32'hBF800000,
                        32'hC0A00000, 32'h0, 32'h3F800000, 32'hC0A00000));
        send_tri(mk_tri(32'hBF800000, 32'hBF800000, 32'h322BCC77, 32'h3F800000, 32'hBF800000,
                        32'h322BCC77, 32'h0, 32'h3F800000, 32'h322BCC77));
        // NaN and infinite corners inside an otherwise good hit
        send_tri(mk_tri(32'h7FC00000, 32'hBF800000, 32'h40A00000, 32'h3F800000, 32'hBF800000,
                        32'h40A00000, 32'h0, 32'h3F800000, 32'h40A00000));
        send_tri(mk_tri(32'hBF800000, 32'hBF800000, 32'h40A00000, 32'h7F800000, 32'hBF800000,
                        32'h40A00000, 32'h0, 32'h3F800000, 32'h40A00000));
        send_tri(mk_tri(32'hBF800000, 32'hBF800000, 32'h40A00000, 32'h3F800000, 32'hBF800000,
                        32'h40A00000, 32'h0, 32'hFF800000, 32'h40A00000));
        // huge and subnormal-sized triangles
        send_tri(mk_tri(32'hFF7FFFFF, 32'hFF7FFFFF, 32'h7F7FFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF,
                        32'h7F7FFFFF, 32'h0, 32'h7F7FFFFF, 32'h7F7FFFFF));
        send_tri(mk_tri(32'h807FFFFF, 32'h807FFFFF, 32'h00000010, 32'h007FFFFF, 32'h807FFFFF,
                        32'h00000010, 32'h0, 32'h007FFFFF, 32'h00000010));
        send_tri(mk_tri(32'hBF800000, 32'hBF800000, 32'h00000001, 32'h3F800000, 32'hBF800000,
                        32'h00000001, 32'h0, 32'h3F800000, 32'h00000001));
        // determinant right around the parallel threshold
        send_tri(mk_tri(32'h0, 32'h0, 32'h3F800000, 32'h33D6BF95, 32'h0,
                        32'h3F800000, 32'h0, 32'h3F800000, 32'h3F800000));
        send_tri(mk_tri(32'h0, 32'h0, 32'h3F800000, 32'h33D6BF96, 32'h0,
                        32'h3F800000, 32'h0, 32'h3F800000, 32'h3F800000));
        send_tri(mk_tri(32'h0, 32'h0, 32'h3F800000, 32'h33D6BF94, 32'h0,
                        32'h3F800000, 32'h0, 32'h3F800000, 32'h3F800000));
        // uniform field extremes
        send_tri('0);
        send_tri('1);
        send_tri({9{32'h7F800000}});
        send_tri({9{32'h80000000}});
        send_tri({9{32'h7FFFFFFF}});
        send_tri({9{32'h7F7FFFFF}});
        @(negedge clk);
        tri_valid = 1'b0;

        run_phase(0);
        set_ray(32'h3F000000, 32'hBE800000, 32'hC0000000, 32'h0, 32'h0, 32'h3F800000);
        run_phase(1);
        set_ray(32'h0, 32'h0, 32'h0, 32'h3DCCCCCD, 32'h3D4CCCCD, 32'h3F800000);
        run_phase(2);
        set_ray(32'h0, 32'h0, 32'h41A00000, 32'h0, 32'h0, 32'hBF800000);
        run_phase(3);
        set_ray(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7F800000, 32'h7F800000,
                32'h7F800000);
        run_phase(4);
        set_ray(32'h7F7FFFFF, 32'h00000001, 32'h80000000, 32'h00000001, 32'h80000000,
                32'hFF7FFFFF);
        run_phase(5);
        set_ray(32'h80000000, $urandom, 32'hBF000000, 32'h0, 32'h80000000, 32'h3F800000);
        run_phase(6);
        set_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        run_phase(7);

        // Wait out the last results
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rti_pkg.sv
hw/rtl/rti_delay.sv
hw/rtl/rti_fmul.sv
hw/rtl/rti_fadd.sv
hw/rtl/rti_frecip.sv
hw/rtl/ray_triangle_intersect_top.sv
verif/ray_hit_checker.sv
verif/tb_top.sv
